// ----- hdl/dlc_pkg.sv -----
// Shared types, codes, reset values and level helper for the dimmer controller.
package dlc_pkg;

   // Request kinds
   localparam logic [1:0] REQ_LEVEL = 2'd0;
   localparam logic [1:0] REQ_UP    = 2'd1;
   localparam logic [1:0] REQ_DOWN  = 2'd2;
   localparam logic [1:0] REQ_TICK  = 2'd3;

   // Level command codes
   localparam logic [7:0] CMD_OFF    = 8'h00;
   localparam logic [7:0] CMD_ON     = 8'hFF;
   localparam logic [7:0] CMD_TOGGLE = 8'hFE;

   // Report kinds
   localparam logic REPORT_POWER = 1'b0;
   localparam logic REPORT_LEVEL = 1'b1;

   // Register indexes (byte address / 4)
   localparam logic [2:0] REG_MAX_LEVEL    = 3'd0;
   localparam logic [2:0] REG_STEP_SIZE    = 3'd1;
   localparam logic [2:0] REG_DEBOUNCE     = 3'd2;
   localparam logic [2:0] REG_FIRST_REPEAT = 3'd3;
   localparam logic [2:0] REG_NEXT_REPEAT  = 3'd4;

   // Register reset values
   localparam logic [7:0]  MAX_LEVEL_RST    = 8'd100;
   localparam logic [5:0]  STEP_SIZE_RST    = 6'd6;
   localparam logic [15:0] DEBOUNCE_RST     = 16'd30;
   localparam logic [15:0] FIRST_REPEAT_RST = 16'd600;
   localparam logic [15:0] NEXT_REPEAT_RST  = 16'd100;

   // Result queue depth; a tick may push two results at once
   localparam int QUEUE_DEPTH = 4;

   typedef struct packed {
      logic [7:0]  max_level;
      logic [5:0]  step_size;
      logic [15:0] debounce_ticks;
      logic [15:0] first_repeat_ticks;
      logic [15:0] next_repeat_ticks;
   } cfg_type;

   typedef struct packed {
      logic [7:0] drive_level;
      logic       relay_on;
      logic       report_kind;
      logic [7:0] stored_level;
      logic       last;
   } rsp_item_type;

   typedef struct packed {
      logic [1:0]   count;
      rsp_item_type item0;
      rsp_item_type item1;
   } rsp_push_type;

   // Clamp a requested level and drive it; a nonzero drive becomes the stored level.
   function automatic rsp_item_type apply_level(input logic [8:0] lvl,
                                                input logic       relay,
                                                input logic [7:0] max_level,
                                                input logic [7:0] level,
                                                input logic       kind);
      rsp_item_type r;
      logic [8:0]   clamped;
      clamped = (lvl > {1'b0, max_level}) ? {1'b0, max_level} : lvl;
      r.drive_level  = relay ? clamped[7:0] : 8'd0;
      r.relay_on     = relay;
      r.report_kind  = kind;
      r.stored_level = (r.drive_level != 8'd0) ? r.drive_level : level;
      r.last         = 1'b0;
      return r;
   endfunction

endpackage

// ----- hdl/dlc_csr.sv -----
// Configuration register file behind the APB-style port.
module dlc_csr
   import dlc_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        csr_psel,
   input  logic        csr_penable,
   input  logic        csr_pwrite,
   input  logic [4:0]  csr_paddr,
   input  logic [31:0] csr_pwdata,
   output logic [31:0] csr_prdata,
   output logic        csr_pready,
   output cfg_type     cfg
);

   cfg_type    cfg_ff;
   logic       wr_en;
   logic [2:0] reg_idx;

   assign reg_idx    = csr_paddr[4:2];
   assign wr_en      = csr_psel && csr_penable && csr_pwrite;
   assign csr_pready = 1'b1;
   assign cfg        = cfg_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.max_level          <= MAX_LEVEL_RST;
         cfg_ff.step_size          <= STEP_SIZE_RST;
         cfg_ff.debounce_ticks     <= DEBOUNCE_RST;
         cfg_ff.first_repeat_ticks <= FIRST_REPEAT_RST;
         cfg_ff.next_repeat_ticks  <= NEXT_REPEAT_RST;
      end else if (wr_en) begin
         case (reg_idx)
            REG_MAX_LEVEL:    cfg_ff.max_level          <= csr_pwdata[7:0];
            REG_STEP_SIZE:    cfg_ff.step_size          <= csr_pwdata[5:0];
            REG_DEBOUNCE:     cfg_ff.debounce_ticks     <= csr_pwdata[15:0];
            REG_FIRST_REPEAT: cfg_ff.first_repeat_ticks <= csr_pwdata[15:0];
            REG_NEXT_REPEAT:  cfg_ff.next_repeat_ticks  <= csr_pwdata[15:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      case (reg_idx)
         REG_MAX_LEVEL:    csr_prdata = {24'd0, cfg_ff.max_level};
         REG_STEP_SIZE:    csr_prdata = {26'd0, cfg_ff.step_size};
         REG_DEBOUNCE:     csr_prdata = {16'd0, cfg_ff.debounce_ticks};
         REG_FIRST_REPEAT: csr_prdata = {16'd0, cfg_ff.first_repeat_ticks};
         REG_NEXT_REPEAT:  csr_prdata = {16'd0, cfg_ff.next_repeat_ticks};
         default:          csr_prdata = 32'd0;
      endcase
   end

endmodule

// ----- hdl/dlc_engine.sv -----
// Input register, dimmer state and the single-pass update that yields up to two results.
module dlc_engine
   import dlc_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  cfg_type      cfg,
   input  logic         req_valid,
   output logic         req_stall,
   input  logic [1:0]   req_type,
   input  logic [7:0]   req_level_cmd,
   input  logic         req_up_held,
   input  logic         req_down_held,
   input  logic         queue_room,
   output rsp_push_type push
);

   // Input register
   logic       in_vld_ff, in_vld_in;
   logic [1:0] in_type_ff;
   logic [7:0] in_cmd_ff;
   logic       in_up_ff, in_dn_ff;
   logic       proc_go, load_in;

   // Dimmer state
   logic [7:0]  level_ff, level_in;
   logic        relay_ff, relay_in;
   logic        first_press_ff, first_press_in;
   logic        up_act_ff, up_act_in;
   logic [15:0] up_cnt_ff, up_cnt_in;
   logic        dn_act_ff, dn_act_in;
   logic [15:0] dn_cnt_ff, dn_cnt_in;

   rsp_item_type item_a, item_b;
   logic         have_a, have_b;
   logic [7:0]   level_mid;
   logic         fp_mid;
   logic [8:0]   up_sum;
   logic [7:0]   step_plus_one;

   assign proc_go   = in_vld_ff && queue_room;
   assign req_stall = in_vld_ff && !queue_room;
   assign load_in   = req_valid && !req_stall;
   assign in_vld_in = load_in || (in_vld_ff && !proc_go);

   assign up_sum        = {1'b0, level_ff} + {3'd0, cfg.step_size};
   assign step_plus_one = {2'd0, cfg.step_size} + 8'd1;

   always_ff @(posedge clock) begin
      if (reset) begin
         in_vld_ff <= 1'b0;
      end else begin
         in_vld_ff <= in_vld_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load_in) begin
         in_type_ff <= req_type;
         in_cmd_ff  <= req_level_cmd;
         in_up_ff   <= req_up_held;
         in_dn_ff   <= req_down_held;
      end
   end

   always_comb begin
      level_in       = level_ff;
      relay_in       = relay_ff;
      first_press_in = first_press_ff;
      up_act_in      = up_act_ff;
      up_cnt_in      = up_cnt_ff;
      dn_act_in      = dn_act_ff;
      dn_cnt_in      = dn_cnt_ff;
      item_a         = '0;
      item_b         = '0;
      have_a         = 1'b0;
      have_b         = 1'b0;
      level_mid      = level_ff;
      fp_mid         = first_press_ff;

      case (in_type_ff)
         REQ_LEVEL: begin
            have_a = 1'b1;
            if (in_cmd_ff == CMD_ON) begin
               relay_in = 1'b1;
               item_a   = apply_level({1'b0, level_ff}, 1'b1, cfg.max_level, level_ff,
                                      REPORT_POWER);
            end else if (in_cmd_ff == CMD_TOGGLE) begin
               relay_in = !relay_ff;
               item_a   = apply_level({1'b0, level_ff}, !relay_ff, cfg.max_level, level_ff,
                                      REPORT_POWER);
            end else if (in_cmd_ff == CMD_OFF) begin
               relay_in = 1'b0;
               item_a   = apply_level(9'd0, 1'b0, cfg.max_level, level_ff, REPORT_POWER);
            end else begin
               relay_in = 1'b1;
               item_a   = apply_level({1'b0, in_cmd_ff}, 1'b1, cfg.max_level, level_ff,
                                      REPORT_LEVEL);
            end
            level_in = item_a.stored_level;
         end
         REQ_UP: begin
            first_press_in = 1'b1;
            up_act_in      = 1'b1;
            up_cnt_in      = cfg.debounce_ticks;
         end
         REQ_DOWN: begin
            first_press_in = 1'b1;
            dn_act_in      = 1'b1;
            dn_cnt_in      = cfg.debounce_ticks;
         end
         REQ_TICK: begin
            // Up timer goes first; the down timer sees its level and first-press
            if (up_act_ff) begin
               if (up_cnt_ff <= 16'd1) begin
                  if (!in_up_ff) begin
                     up_act_in = 1'b0;
                  end else begin
                     if (level_ff < cfg.max_level) begin
                        have_a    = 1'b1;
                        relay_in  = 1'b1;
                        item_a    = apply_level(up_sum, 1'b1, cfg.max_level, level_ff,
                                                REPORT_LEVEL);
                        level_mid = item_a.stored_level;
                     end
                     up_cnt_in = first_press_ff ? cfg.first_repeat_ticks
                                                : cfg.next_repeat_ticks;
                     fp_mid    = 1'b0;
                  end
               end else begin
                  up_cnt_in = up_cnt_ff - 16'd1;
               end
            end
            level_in       = level_mid;
            first_press_in = fp_mid;
            if (dn_act_ff) begin
               if (dn_cnt_ff <= 16'd1) begin
                  if (!in_dn_ff) begin
                     dn_act_in = 1'b0;
                  end else begin
                     if (level_mid > step_plus_one) begin
                        have_b = 1'b1;
                        item_b = apply_level({1'b0, level_mid - {2'd0, cfg.step_size}},
                                             1'b1, cfg.max_level, level_mid, REPORT_LEVEL);
                     end else if (level_mid > 8'd1) begin
                        have_b = 1'b1;
                        item_b = apply_level(9'd1, 1'b1, cfg.max_level, level_mid,
                                             REPORT_LEVEL);
                     end
                     if (have_b) begin
                        relay_in = 1'b1;
                        level_in = item_b.stored_level;
                     end
                     dn_cnt_in      = fp_mid ? cfg.first_repeat_ticks
                                             : cfg.next_repeat_ticks;
                     first_press_in = 1'b0;
                  end
               end else begin
                  dn_cnt_in = dn_cnt_ff - 16'd1;
               end
            end
         end
         default: ;
      endcase

      // Pack results in order and flag the final one
      push = '0;
      if (proc_go) begin
         if (have_a && have_b) begin
            push.count      = 2'd2;
            push.item0      = item_a;
            push.item1      = item_b;
            push.item1.last = 1'b1;
         end else if (have_a) begin
            push.count      = 2'd1;
            push.item0      = item_a;
            push.item0.last = 1'b1;
         end else if (have_b) begin
            push.count      = 2'd1;
            push.item0      = item_b;
            push.item0.last = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         level_ff       <= MAX_LEVEL_RST;
         relay_ff       <= 1'b0;
         first_press_ff <= 1'b1;
         up_act_ff      <= 1'b0;
         up_cnt_ff      <= 16'd0;
         dn_act_ff      <= 1'b0;
         dn_cnt_ff      <= 16'd0;
      end else if (proc_go) begin
         level_ff       <= level_in;
         relay_ff       <= relay_in;
         first_press_ff <= first_press_in;
         up_act_ff      <= up_act_in;
         up_cnt_ff      <= up_cnt_in;
         dn_act_ff      <= dn_act_in;
         dn_cnt_ff      <= dn_cnt_in;
      end
   end

endmodule

// ----- hdl/dlc_rsp_queue.sv -----
// Small result queue that takes up to two results a cycle and hands out one while rsp_stall is low.
module dlc_rsp_queue
   import dlc_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  rsp_push_type push,
   output logic         queue_room,
   output logic         rsp_valid,
   input  logic         rsp_stall,
   output rsp_item_type rsp_item
);

   localparam int PTR_W = $clog2(QUEUE_DEPTH);
   localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

   rsp_item_type       mem [QUEUE_DEPTH];
   logic [PTR_W-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0]   count_ff, count_in;
   logic [PTR_W-1:0]   wr_next;
   logic               pop;

   assign rsp_valid  = (count_ff != '0);
   assign pop        = rsp_valid && !rsp_stall;
   assign queue_room = (count_ff <= CNT_W'(QUEUE_DEPTH - 2));
   assign rsp_item   = mem[rd_ptr_ff];
   assign wr_next    = wr_ptr_ff + PTR_W'(1);

   assign wr_ptr_in = wr_ptr_ff + PTR_W'(push.count);
   assign rd_ptr_in = rd_ptr_ff + PTR_W'(pop);
   assign count_in  = count_ff + CNT_W'(push.count) - CNT_W'(pop);

   always_ff @(posedge clock) begin
      if (push.count != 2'd0) begin
         mem[wr_ptr_ff] <= push.item0;
      end
      if (push.count == 2'd2) begin
         mem[wr_next] <= push.item1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

endmodule

// ----- hdl/dimmer_level_controller_top.sv -----
// Dimmer level controller: one request per cycle while req_stall is low.
// A request is taken every cycle while the four-entry result queue has two free
// slots. A level command gives one result, a button edge none and a tick up to two
// (up button first), which leave the queue in that order. The request is held in
// an input register, and the state update and result packing are one pass of logic
// into the result queue, so a result passes through the input register and then
// the result queue. Configuration registers sit at byte addresses 0, 4, 8, 12 and 16.
module dimmer_level_controller_top
   import dlc_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        csr_psel,
   input  logic        csr_penable,
   input  logic        csr_pwrite,
   input  logic [4:0]  csr_paddr,
   input  logic [31:0] csr_pwdata,
   output logic [31:0] csr_prdata,
   output logic        csr_pready,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [1:0]  req_type,
   input  logic [7:0]  req_level_cmd,
   input  logic        req_up_held,
   input  logic        req_down_held,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [7:0]  rsp_drive_level,
   output logic        rsp_relay_on,
   output logic        rsp_report_kind,
   output logic [7:0]  rsp_stored_level,
   output logic        rsp_last
);

   cfg_type      cfg;
   rsp_push_type push;
   logic         queue_room;
   rsp_item_type rsp_item;

   dlc_csr u_csr (
      .clock       (clock),
      .reset       (reset),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready),
      .cfg         (cfg)
   );

   dlc_engine u_engine (
      .clock         (clock),
      .reset         (reset),
      .cfg           (cfg),
      .req_valid     (req_valid),
      .req_stall     (req_stall),
      .req_type      (req_type),
      .req_level_cmd (req_level_cmd),
      .req_up_held   (req_up_held),
      .req_down_held (req_down_held),
      .queue_room    (queue_room),
      .push          (push)
   );

   dlc_rsp_queue u_rsp_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .queue_room (queue_room),
      .rsp_valid  (rsp_valid),
      .rsp_stall  (rsp_stall),
      .rsp_item   (rsp_item)
   );

   assign rsp_drive_level  = rsp_item.drive_level;
   assign rsp_relay_on     = rsp_item.relay_on;
   assign rsp_report_kind  = rsp_item.report_kind;
   assign rsp_stored_level = rsp_item.stored_level;
   assign rsp_last         = rsp_item.last;

endmodule
